// ===== sv/rms_current_power_meter_defines.svh =====
// Assertion macros for the RMS current and power meter.
`ifndef RMS_CURRENT_POWER_METER_DEFINES_SVH
`define RMS_CURRENT_POWER_METER_DEFINES_SVH

`ifndef SYNTHESIS

`define RCPM_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define RCPM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RCPM_ASSERT(name, expr, msg)

`define RCPM_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== sv/rcpm_pkg.sv =====
// Shared widths, register indexes and constants of the RMS current and power meter.
package rcpm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 40;
	localparam int COUNT_W  = 16;
	localparam int UV_W     = 28;
	localparam int SAT_W    = 16;
	localparam int CFG_W    = 24;
	localparam int IDX_W    = 3;
	localparam int ROOT_W   = 20;
	localparam int MA_W     = 20;
	localparam int STEP_W   = 6;

	localparam logic [IDX_W-1:0] REG_OFFSET_CODE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
	localparam logic [IDX_W-1:0] REG_UV_PER_COUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_MA_PER_COUNT = 3'd3;
	localparam logic [IDX_W-1:0] REG_LINE_VOLTAGE = 3'd4;

	localparam logic [11:0] OFFSET_RESET = 12'd1514;
	localparam logic [15:0] COUNT_RESET  = 16'd2000;
	localparam logic [23:0] UV_RESET     = 24'd206250;
	localparam logic [15:0] MA_RESET     = 16'd2989;
	localparam logic [9:0]  LINE_RESET   = 10'd220;

	localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd40;
	localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd20;

	// ceil(2^38 / 1000): exact floor divide by 1000 for products below 2^30
	localparam logic [28:0] PW_RECIP = 29'd274877907;
	localparam int          PW_SHIFT = 38;

endpackage

// ===== sv/rms_current_power_meter.sv =====
// RMS current and apparent power meter: accumulator, shared divide/root step unit, multiplier.
//
//  channel   signals                              width
//  sample    sample_valid sample_ready sample     12
//  result    result_valid result_ready rms_uv     28
//            current_ma power_w                   16, 16
//  config    cfg_we cfg_index cfg_data            1, 3, 24
//
// A sample that does not close its window is squared and accumulated before the next one is
// taken. A closing sample is squared and accumulated, then runs 40 restoring divide steps
// for the mean and 20 root steps on one compare-subtract unit, 4 passes through one 32x32
// multiplier (uv, ma, power, reciprocal multiply to divide by 1000), then loads the output.
// Reset clears the accumulator, the sample counter and the sequencer, and loads the
// register defaults. A stalled result holds in the output register; the sequencer waits
// only if a second result is ready before the first is taken.
`include "rms_current_power_meter_defines.svh"

module rms_current_power_meter
	import rcpm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [UV_W-1:0]     rms_uv,
	output logic [SAT_W-1:0]    current_ma,
	output logic [SAT_W-1:0]    power_w
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SQUARE   = 4'd1;
	localparam logic [3:0] ST_ACCUM    = 4'd2;
	localparam logic [3:0] ST_DIV      = 4'd3;
	localparam logic [3:0] ST_SQRT     = 4'd4;
	localparam logic [3:0] ST_MUL_UV   = 4'd5;
	localparam logic [3:0] ST_MUL_MA   = 4'd6;
	localparam logic [3:0] ST_MUL_PW   = 4'd7;
	localparam logic [3:0] ST_SCALE_PW = 4'd8;
	localparam logic [3:0] ST_DONE     = 4'd9;

	logic [3:0]          state_q;
	logic [11:0]         offset_q;
	logic [15:0]         count_cfg_q;
	logic [23:0]         uv_cfg_q;
	logic [15:0]         ma_cfg_q;
	logic [9:0]          line_cfg_q;

	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic [47:0]         prod_q;
	logic [SUM_W-1:0]    quo_q;
	logic [20:0]         rem_q;
	logic [15:0]         div_q;
	logic [ROOT_W-1:0]   root_q;
	logic [STEP_W-1:0]   step_q;
	logic [UV_W-1:0]     uv_q;
	logic [MA_W-1:0]     ma_q;

	logic                result_valid_q;
	logic [UV_W-1:0]     rms_uv_q;
	logic [SAT_W-1:0]    current_ma_q;
	logic [SAT_W-1:0]    power_w_q;

	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         mul_p;
	logic [22:0]         cmp_a;
	logic [22:0]         cmp_b;
	logic [23:0]         cmp_d;
	logic                cmp_ge;
	logic [SUM_W-1:0]    quo_step;
	logic [SUM_W-1:0]    sum_nx;
	logic [COUNT_W-1:0]  cnt_nx;
	logic [COUNT_W-1:0]  target;
	logic                emit;
	logic [SAMPLE_W-1:0] mag_nx;
	logic                out_free;

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign rms_uv       = rms_uv_q;
	assign current_ma   = current_ma_q;
	assign power_w      = power_w_q;
	assign out_free     = !result_valid_q || result_ready;

	assign mag_nx = (sample >= offset_q) ? (sample - offset_q) : (offset_q - sample);
	assign target = (count_cfg_q == '0) ? 16'd1 : count_cfg_q;
	assign sum_nx = sum_q + {16'd0, prod_q[23:0]};
	assign cnt_nx = cnt_q + 16'd1;
	assign emit   = (cnt_nx == '0) || (cnt_nx >= target);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQUARE: begin
				mul_a = {20'd0, mag_q};
				mul_b = {20'd0, mag_q};
			end
			ST_MUL_UV: begin
				mul_a = {12'd0, root_q};
				mul_b = {8'd0, uv_cfg_q};
			end
			ST_MUL_MA: begin
				mul_a = {12'd0, root_q};
				mul_b = {16'd0, ma_cfg_q};
			end
			ST_MUL_PW: begin
				mul_a = {12'd0, prod_q[35:16]};
				mul_b = {22'd0, line_cfg_q};
			end
			ST_SCALE_PW: begin
				mul_a = {2'd0, prod_q[29:0]};
				mul_b = {3'd0, PW_RECIP};
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		unique case (state_q)
			ST_DIV: begin
				cmp_a = {6'd0, rem_q[15:0], quo_q[SUM_W-1]};
				cmp_b = {7'd0, div_q};
			end
			ST_SQRT: begin
				cmp_a = {rem_q, quo_q[SUM_W-1:SUM_W-2]};
				cmp_b = {1'b0, root_q, 2'b01};
			end
			default: begin
			end
		endcase
	end

	assign cmp_d    = {1'b0, cmp_a} - {1'b0, cmp_b};
	assign cmp_ge   = !cmp_d[23];
	assign quo_step = {quo_q[SUM_W-2:0], cmp_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= OFFSET_RESET;
			count_cfg_q <= COUNT_RESET;
			uv_cfg_q    <= UV_RESET;
			ma_cfg_q    <= MA_RESET;
			line_cfg_q  <= LINE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_CODE:  offset_q    <= cfg_data[11:0];
				REG_SAMPLE_COUNT: count_cfg_q <= cfg_data[15:0];
				REG_UV_PER_COUNT: uv_cfg_q    <= cfg_data;
				REG_MA_PER_COUNT: ma_cfg_q    <= cfg_data[15:0];
				REG_LINE_VOLTAGE: line_cfg_q  <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sum_q          <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: state_q <= ST_ACCUM;
				ST_ACCUM: begin
					if (emit) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						sum_q   <= sum_nx;
						cnt_q   <= cnt_nx;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_MUL_UV;
					end
				end
				ST_MUL_UV:   state_q <= ST_MUL_MA;
				ST_MUL_MA:   state_q <= ST_MUL_PW;
				ST_MUL_PW:   state_q <= ST_SCALE_PW;
				ST_SCALE_PW: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q <= mag_nx;
			end
			ST_SQUARE: begin
				prod_q <= mul_p[47:0];
			end
			ST_ACCUM: begin
				quo_q  <= sum_nx;
				rem_q  <= '0;
				div_q  <= cnt_nx;
				step_q <= DIV_STEPS - 6'd1;
			end
			ST_DIV: begin
				if (step_q == '0) begin
					quo_q  <= {quo_step[23:0], 16'd0};
					rem_q  <= '0;
					root_q <= '0;
					step_q <= SQRT_STEPS - 6'd1;
				end else begin
					quo_q  <= quo_step;
					rem_q  <= cmp_ge ? {5'd0, cmp_d[15:0]} : {5'd0, cmp_a[15:0]};
					step_q <= step_q - 6'd1;
				end
			end
			ST_SQRT: begin
				rem_q  <= cmp_ge ? cmp_d[20:0] : cmp_a[20:0];
				root_q <= {root_q[ROOT_W-2:0], cmp_ge};
				quo_q  <= {quo_q[SUM_W-3:0], 2'b00};
				step_q <= step_q - 6'd1;
			end
			ST_MUL_UV: begin
				prod_q <= mul_p[47:0];
			end
			ST_MUL_MA: begin
				uv_q   <= prod_q[UV_W+15:16];
				prod_q <= mul_p[47:0];
			end
			ST_MUL_PW: begin
				ma_q   <= prod_q[35:16];
				prod_q <= mul_p[47:0];
			end
			ST_SCALE_PW: begin
				quo_q <= SUM_W'(mul_p[63:PW_SHIFT]);
			end
			ST_DONE: begin
				if (out_free) begin
					rms_uv_q     <= uv_q;
					current_ma_q <= (ma_q[MA_W-1:SAT_W] != '0) ? '1 : ma_q[SAT_W-1:0];
					power_w_q    <= (quo_q[29:SAT_W] != '0) ? '1 : quo_q[SAT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	`RCPM_ASSERT_NEXT(a_result_from_done, !result_valid_q || result_ready, !result_valid_q || $past(state_q) == ST_DONE, "result raised outside the final state")
	`RCPM_ASSERT(a_step_bound, state_q != ST_DIV || step_q < DIV_STEPS, "divide step count out of range")
	`RCPM_ASSERT(a_rem_below_divisor, state_q != ST_DIV || rem_q[15:0] < div_q, "divide remainder not below divisor")
	`RCPM_ASSERT(a_window_cleared, (state_q != ST_DIV && state_q != ST_SQRT) || (cnt_q == '0 && sum_q == '0), "window not cleared during result work")

endmodule
